// File: hdl/rssc_pkg.sv
// Shared types, constants and GF(2^8) helpers for the RS syndrome calculator.
package rssc_pkg;

   localparam int SYMBOL_WIDTH          = 8;
   localparam int POLY_WIDTH            = 9;
   localparam int NUM_SYN_WIDTH         = 6;
   localparam int SYN_INDEX_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH       = 1;
   localparam int CSR_DATA_WIDTH        = 9;
   localparam int MAX_SYNDROMES_DEFAULT = 32;
   localparam int RESULT_LIMIT          = 32;

   localparam logic [POLY_WIDTH-1:0]    POLY_RESET    = 9'd285;
   localparam logic [NUM_SYN_WIDTH-1:0] NUM_SYN_RESET = 6'd16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FIELD_POLYNOMIAL = 1'b0,
      CSR_NUM_SYNDROMES    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic update;
      logic capture;
      logic shift;
   } cell_ctrl_type;

   // Multiply by alpha: shift up, fold the carry back with the low polynomial bits.
   function automatic logic [SYMBOL_WIDTH-1:0] gf_double(
      input logic [SYMBOL_WIDTH-1:0] v,
      input logic [SYMBOL_WIDTH-1:0] poly
   );
      return {v[SYMBOL_WIDTH-2:0], 1'b0} ^ (v[SYMBOL_WIDTH-1] ? poly : '0);
   endfunction

   function automatic logic [SYMBOL_WIDTH-1:0] gf_mul(
      input logic [SYMBOL_WIDTH-1:0] a,
      input logic [SYMBOL_WIDTH-1:0] b,
      input logic [SYMBOL_WIDTH-1:0] poly
   );
      logic [SYMBOL_WIDTH-1:0] p;
      p = '0;
      for (int k = SYMBOL_WIDTH - 1; k >= 0; k--) begin
         p = gf_double(p, poly) ^ (b[k] ? a : '0);
      end
      return p;
   endfunction

endpackage

// File: hdl/rssc_if.sv
// Stream interfaces for codeword bytes in and syndrome results out.
interface rssc_req_if import rssc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SYMBOL_WIDTH-1:0] data_byte;
   logic                    last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface rssc_rsp_if import rssc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [SYN_INDEX_WIDTH-1:0] syndrome_index;
   logic [SYMBOL_WIDTH-1:0]    syndrome_value;
   logic                       last_syndrome;
   logic                       no_error;

   modport source (output valid, syndrome_index, syndrome_value, last_syndrome, no_error,
                   input ready);
   modport sink   (input valid, syndrome_index, syndrome_value, last_syndrome, no_error,
                   output ready);
endinterface

// File: hdl/rssc_cell.sv
// One syndrome cell: alpha power, Horner accumulator and a stage of the unload chain.
module rssc_cell import rssc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic [SYMBOL_WIDTH-1:0] poly,
   input  logic [SYMBOL_WIDTH-1:0] data_byte,
   input  logic [SYMBOL_WIDTH-1:0] pow_in,
   output logic [SYMBOL_WIDTH-1:0] pow_out,
   input  logic [SYMBOL_WIDTH-1:0] snap_in,
   output logic [SYMBOL_WIDTH-1:0] snap_out,
   output logic                    nonzero
);

   logic [SYMBOL_WIDTH-1:0] pow_ff;
   logic [SYMBOL_WIDTH-1:0] acc_ff;
   logic [SYMBOL_WIDTH-1:0] acc_in;
   logic [SYMBOL_WIDTH-1:0] snap_ff;
   logic                    nz_ff;

   assign acc_in   = data_byte ^ gf_mul(acc_ff, pow_ff, poly);
   assign pow_out  = gf_double(pow_ff, poly);
   assign snap_out = snap_ff;
   assign nonzero  = nz_ff;

   // Power of alpha ripples down from the neighbour.
   always_ff @(posedge clock) begin
      pow_ff <= pow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.update) begin
         acc_ff <= ctrl.capture ? '0 : acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update && ctrl.capture) begin
         snap_ff <= acc_in;
         nz_ff   <= |acc_in;
      end else if (ctrl.shift) begin
         snap_ff <= snap_in;
      end
   end

endmodule

// File: hdl/rs_gf256_syndrome_calculator.sv
// Top level of the GF(2^8) Reed-Solomon syndrome calculator.
// Takes one codeword byte per cycle, highest coefficient first, into a row of
// MAX_SYNDROMES cells; cell i holds alpha^i and updates its accumulator by
// Horner's rule on every byte, so bytes inside a codeword stream at one item
// per cycle. The byte flagged last copies every updated accumulator into the
// cell's unload stage and clears the accumulator; after the ST_SCAN state the
// syndromes leave one item per cycle while rsp_chan.ready is high (index,
// value, last flag, all-zero flag) by shifting the unload stages towards
// cell 0. While that run of n syndromes is unloading, following bytes are
// still taken; only the next last byte waits until the run has gone. The
// alpha powers ripple one cell per cycle from the configured polynomial:
// after reset and after every write of the polynomial register the block
// takes no byte while the powers settle. The syndrome count is clamped to
// 1 .. min(MAX_SYNDROMES, 32).
module rs_gf256_syndrome_calculator import rssc_pkg::*; #(
   parameter int MAX_SYNDROMES = MAX_SYNDROMES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   rssc_req_if.sink                   req_chan,
   rssc_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int LIMIT = (MAX_SYNDROMES < RESULT_LIMIT) ? MAX_SYNDROMES : RESULT_LIMIT;
   localparam int N_W   = $clog2(LIMIT + 1);
   localparam int SET_W = $clog2(MAX_SYNDROMES + 1);

   // Configuration registers
   logic [POLY_WIDTH-1:0]    poly_ff;
   logic [NUM_SYN_WIDTH-1:0] num_ff;
   logic [SET_W-1:0]         settle_ff;

   // Sequencing
   state_type        state_ff;
   state_type        state_in;
   logic [N_W-1:0]   n_ff;
   logic [N_W-1:0]   n_sel;
   logic [N_W-1:0]   idx_ff;
   logic             noerr_ff;
   logic             busy;
   logic             req_fire;
   logic             rsp_fire;
   logic             idx_last;
   cell_ctrl_type    ctrl;

   // Cell row links
   logic [SYMBOL_WIDTH-1:0]  pow_link  [MAX_SYNDROMES];
   logic [SYMBOL_WIDTH-1:0]  snap_link [MAX_SYNDROMES+1];
   logic [MAX_SYNDROMES-1:0] nz_flag;
   logic [MAX_SYNDROMES-1:0] n_mask;

   // Configuration writes; a polynomial write restarts the power settling.
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= POLY_RESET;
         num_ff    <= NUM_SYN_RESET;
         settle_ff <= SET_W'(MAX_SYNDROMES);
      end else begin
         if (csr_write_enable && csr_index == CSR_FIELD_POLYNOMIAL) begin
            poly_ff   <= csr_write_data[POLY_WIDTH-1:0];
            settle_ff <= SET_W'(MAX_SYNDROMES);
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
         if (csr_write_enable && csr_index == CSR_NUM_SYNDROMES) begin
            num_ff <= csr_write_data[NUM_SYN_WIDTH-1:0];
         end
      end
   end

   // Clamp the syndrome count to 1 .. LIMIT.
   always_comb begin
      if (num_ff == '0) begin
         n_sel = N_W'(1);
      end else if (int'(num_ff) > LIMIT) begin
         n_sel = N_W'(LIMIT);
      end else begin
         n_sel = N_W'(num_ff);
      end
   end

   // Hold every byte back while the powers settle, and a last byte while the previous run is still unloading.
   assign busy           = (state_ff != ST_IDLE);
   assign req_chan.ready = (settle_ff == '0) && !(busy && req_chan.last_byte);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign idx_last       = (idx_ff == N_W'(n_ff - N_W'(1)));

   assign ctrl.update  = req_fire;
   assign ctrl.capture = req_chan.last_byte;
   assign ctrl.shift   = rsp_fire;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.last_byte) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (rsp_fire && idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs of the sequencer
   always_comb begin
      case (state_ff)
         ST_DUMP: rsp_chan.valid = 1'b1;
         default: rsp_chan.valid = 1'b0;
      endcase
   end

   // Latch the count on capture, then count the run out.
   always_ff @(posedge clock) begin
      if (req_fire && req_chan.last_byte && !busy) begin
         n_ff <= n_sel;
      end
      if (state_ff == ST_SCAN) begin
         idx_ff <= '0;
      end else if (rsp_fire) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Fold the zero flags of the syndromes in use during the scan cycle.
   always_comb begin
      for (int i = 0; i < MAX_SYNDROMES; i++) begin
         n_mask[i] = (i < int'(n_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN) begin
         noerr_ff <= ~|(nz_flag & n_mask);
      end
   end

   // Row of cells: powers flow upward, the unload chain shifts towards cell 0.
   assign snap_link[MAX_SYNDROMES] = '0;

   genvar g;
   generate
      for (g = 0; g < MAX_SYNDROMES; g++) begin : g_cell
         logic [SYMBOL_WIDTH-1:0] pow_in;
         if (g == 0) begin : g_first
            assign pow_in = SYMBOL_WIDTH'(1);
         end else begin : g_rest
            assign pow_in = pow_link[g-1];
         end
         if (g == MAX_SYNDROMES - 1) begin : g_end
            rssc_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (ctrl),
               .poly      (poly_ff[SYMBOL_WIDTH-1:0]),
               .data_byte (req_chan.data_byte),
               .pow_in    (pow_in),
               .pow_out   (),
               .snap_in   (snap_link[g+1]),
               .snap_out  (snap_link[g]),
               .nonzero   (nz_flag[g])
            );
            assign pow_link[g] = '0;
         end else begin : g_mid
            rssc_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .ctrl      (ctrl),
               .poly      (poly_ff[SYMBOL_WIDTH-1:0]),
               .data_byte (req_chan.data_byte),
               .pow_in    (pow_in),
               .pow_out   (pow_link[g]),
               .snap_in   (snap_link[g+1]),
               .snap_out  (snap_link[g]),
               .nonzero   (nz_flag[g])
            );
         end
      end
   endgenerate

   assign rsp_chan.syndrome_index = SYN_INDEX_WIDTH'(idx_ff);
   assign rsp_chan.syndrome_value = snap_link[0];
   assign rsp_chan.last_syndrome  = idx_last;
   assign rsp_chan.no_error       = noerr_ff;

   // A captured codeword always goes to the scan cycle next.
   a_capture_scan: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last_byte) |=> (state_ff == ST_SCAN))
      else $error("capture did not start the scan");

   // The unload index stays inside the latched run length.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (idx_ff < n_ff))
      else $error("syndrome index beyond run length");

   // No byte is taken while the alpha powers settle.
   a_settle_block: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> !req_chan.ready)
      else $error("byte accepted while powers settle");

   // The run ends after its last syndrome is taken.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_chan.last_syndrome) |=> !rsp_chan.valid)
      else $error("results continue past the last syndrome");

endmodule

// File: dv/rssc_syndrome_checker.sv
`timescale 1ns / 1ps
// Syndrome checker: mirrors the syndrome accumulators and compares every result item.
module rssc_syndrome_checker import rssc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   rssc_req_if                        req_chan,
   rssc_rsp_if                        rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                mismatch_count,
   output int unsigned                syndromes_pending
);
   localparam int ACC_COUNT = MAX_SYNDROMES_DEFAULT;

   typedef struct packed {
      logic [SYN_INDEX_WIDTH-1:0] index;
      logic [SYMBOL_WIDTH-1:0]    value;
      logic                       last;
      logic                       clean;
   } syndrome_type;

   logic [POLY_WIDTH-1:0]    field_poly;
   logic [NUM_SYN_WIDTH-1:0] syn_count;
   logic [SYMBOL_WIDTH-1:0]  horner_acc [ACC_COUNT];
   syndrome_type             expected_syndromes [$];

   always @(posedge clock) begin
      syndrome_type            got;
      syndrome_type            want;
      logic [SYMBOL_WIDTH-1:0] v;
      logic [SYMBOL_WIDTH-1:0] any_bits;
      int unsigned             n;
      if (reset) begin
         field_poly = POLY_RESET;
         syn_count  = NUM_SYN_RESET;
         foreach (horner_acc[i]) horner_acc[i] = '0;
         expected_syndromes.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.index = rsp_chan.syndrome_index;
            got.value = rsp_chan.syndrome_value;
            got.last  = rsp_chan.last_syndrome;
            got.clean = rsp_chan.no_error;
            if (expected_syndromes.size() == 0) begin
               $display("%0t: unexpected syndrome: got index %0d value %02h last %0b clean %0b",
                        $time, got.index, got.value, got.last, got.clean);
               mismatch_count++;
            end else begin
               want = expected_syndromes.pop_front();
               if (got !== want) begin
                  $write("%0t: syndrome mismatch: expected index %0d value %02h last %0b",
                         $time, want.index, want.value, want.last);
                  $write(" clean %0b, got index %0d value %02h", want.clean,
                         got.index, got.value);
                  $display(" last %0b clean %0b", got.last, got.clean);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            // every accumulator steps, used or not: acc = byte ^ acc * alpha^i
            for (int i = 0; i < ACC_COUNT; i++) begin
               v = horner_acc[i];
               for (int k = 0; k < i; k++) begin
                  if (v[7]) v = {v[6:0], 1'b0} ^ field_poly[7:0];
                  else      v = {v[6:0], 1'b0};
               end
               horner_acc[i] = req_chan.data_byte ^ v;
            end
            if (req_chan.last_byte) begin
               n = (syn_count == 0) ? 1 : (syn_count > ACC_COUNT) ? ACC_COUNT : syn_count;
               any_bits = '0;
               for (int i = 0; i < n; i++) any_bits |= horner_acc[i];
               for (int i = 0; i < n; i++) begin
                  want.index = SYN_INDEX_WIDTH'(i);
                  want.value = horner_acc[i];
                  want.last  = (i == n - 1);
                  want.clean = (any_bits == '0);
                  expected_syndromes.push_back(want);
               end
               foreach (horner_acc[i]) horner_acc[i] = '0;
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_FIELD_POLYNOMIAL) begin
               field_poly = csr_write_data;
            end else if (csr_index == CSR_NUM_SYNDROMES) begin
               syn_count = csr_write_data[NUM_SYN_WIDTH-1:0];
            end
         end
      end
      syndromes_pending = expected_syndromes.size();
   end

endmodule

// File: dv/tb_rs_gf256_syndrome_calculator.sv
`timescale 1ns / 1ps
// Testbench top: drives codewords and register writes into the syndrome calculator.
module tb_rs_gf256_syndrome_calculator;
   import rssc_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   csr_index_type             csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data;
   int unsigned               mismatch_count;
   int unsigned               syndromes_pending;

   // Idling on both sides is allowed only while this is set.
   bit                        gaps_on;
   int unsigned               items_sent;

   // Field and clamped syndrome count as last written, kept here to build valid codewords.
   logic [POLY_WIDTH-1:0]     cur_poly;
   int unsigned               cur_count;
   logic [7:0]                gen_poly [0:32];  // highest degree first

   rssc_req_if req_if ();
   rssc_rsp_if rsp_if ();

   rs_gf256_syndrome_calculator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rssc_syndrome_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_chan          (req_if),
      .rsp_chan          (rsp_if),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .syndromes_pending (syndromes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs or a syndrome never turns up.
   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: hold ready low in bursts of random length while idling is on.
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 7);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Field product by shift and add, reduced with the low byte of the current polynomial.
   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ cur_poly[7:0]) : {a[6:0], 1'b0};
      end
      return p;
   endfunction

   // Offer one byte; called and returning at a falling edge, valid left high.
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.data_byte = value;
      req_if.last_byte = last;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop valid and hold until every syndrome has come out, then let the block settle.
   task automatic drain_results();
      req_if.valid = 1'b0;
      while (syndromes_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write both registers while idle and rebuild the generator for the new field.
   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] poly_word,
                            input logic [CSR_DATA_WIDTH-1:0] count_word);
      logic [7:0] root;
      drain_results();
      csr_write_enable = 1'b1;
      csr_index        = CSR_FIELD_POLYNOMIAL;
      csr_write_data   = poly_word;
      @(negedge clock);
      csr_index        = CSR_NUM_SYNDROMES;
      csr_write_data   = count_word;
      @(negedge clock);
      csr_write_enable = 1'b0;

      cur_poly  = poly_word;
      cur_count = (count_word[5:0] == 0) ? 1 :
                  (count_word[5:0] > MAX_SYNDROMES_DEFAULT) ? MAX_SYNDROMES_DEFAULT :
                  count_word[5:0];
      // g(x) = product of (x + alpha^i) for i below the syndrome count
      foreach (gen_poly[j]) gen_poly[j] = '0;
      gen_poly[0] = 8'h01;
      root = 8'h01;
      for (int i = 0; i < cur_count; i++) begin
         for (int j = i + 1; j >= 1; j--) gen_poly[j] ^= gf_product(root, gen_poly[j-1]);
         root = gf_product(root, 8'h02);
      end
   endtask

   // Send one codeword: either a multiple of g(x), optionally with one byte hit,
   // or plain random bytes.
   task automatic send_codeword(input bit well_formed, input bit corrupt);
      logic [7:0]  word [0:40];
      logic [7:0]  msg;
      int unsigned len;
      int unsigned msg_len;
      foreach (word[j]) word[j] = '0;
      if (well_formed) begin
         msg_len = $urandom_range(1, 6);
         for (int a = 0; a < msg_len; a++) begin
            msg = 8'($urandom);
            for (int b = 0; b <= cur_count; b++) word[a+b] ^= gf_product(msg, gen_poly[b]);
         end
         len = msg_len + cur_count;
         if (corrupt) word[$urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
      end else begin
         len = $urandom_range(1, 10);
         for (int a = 0; a < len; a++) word[a] = 8'($urandom);
      end
      for (int a = 0; a < len; a++) send_byte(word[a], a == len - 1);
   endtask

   initial begin
      int unsigned phase_start;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FIELD_POLYNOMIAL;
      csr_write_data   = '0;
      gaps_on          = 1'b0;
      items_sent       = 0;
      cur_poly         = POLY_RESET;
      cur_count        = NUM_SYN_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: single-byte codewords at both extremes, then a short one.
      gaps_on = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7f, 1'b1);

      // All-ones low byte, full syndrome count; junk in the unused data bits.
      gaps_on = 1'b0;
      configure(9'd511, {3'b101, 6'd32});
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b1);

      // Polynomial with an empty low byte, count of zero behaves as one.
      configure(9'd256, {3'b010, 6'd0});
      send_byte(8'h01, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h55, 1'b1);

      // Top bit clear, count above the limit saturates.
      configure(9'd29, {3'b111, 6'd63});
      send_byte(8'haa, 1'b0);
      send_byte(8'h01, 1'b1);

      // A clean codeword: every syndrome should come back zero.
      configure(9'h11d, 9'd4);
      send_codeword(1'b1, 1'b0);

      // Random settings, mostly codewords built from g(x), the rest noise.
      for (int p = 0; p < 6; p++) begin
         configure(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
         phase_start = items_sent;
         while (items_sent - phase_start < 15) begin
            // no idling at all in the closing phase
            gaps_on = (p != 5) && ($urandom_range(0, 3) != 0);
            send_codeword($urandom_range(0, 9) < 6, $urandom_range(0, 2) == 0);
            if (p == 1 || $urandom_range(0, 7) == 0) drain_results();
         end
      end

      req_if.valid = 1'b0;
      gaps_on      = 1'b0;
      while (syndromes_pending != 0) @(negedge clock);
      // catch any stray item that follows the last expected one
      repeat (64) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/rssc_pkg.sv
hdl/rssc_if.sv
hdl/rssc_cell.sv
hdl/rs_gf256_syndrome_calculator.sv
dv/rssc_syndrome_checker.sv
dv/tb_rs_gf256_syndrome_calculator.sv
